>>> design/hrpl_pkg.sv
// Package for the hit-to-readout pad locator: codes, constants, types and helpers.
package hrpl_pkg;

   localparam int CW_W      = 33;    // CORDIC datapath width
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IW   = 5;
   localparam int DIV_NUM_W = 42;
   localparam int DIV_DEN_W = 12;
   localparam int DIV_CNT_W = 6;

   localparam logic [29:0] GAIN_INV     = 30'd652032874;
   localparam logic [16:0] TWELFTH_TURN = 17'd5461;

   localparam logic [31:0] ATAN_TABLE [ATAN_DEPTH] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef enum logic [1:0] {
      FN_LOAD_ROW    = 2'd0,
      FN_LOAD_SECTOR = 2'd1,
      FN_LOCATE      = 2'd2,
      FN_PAD_CENTRE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_SECTOR = 3'd1,
      ST_OFF_ROW   = 3'd2,
      ST_PAD_RANGE = 3'd3,
      ST_BAD_ADDR  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEC_CHECK,
      S_VEC_RUN,
      S_MAG_MUL,
      S_SEC_EVAL,
      S_SEC_END,
      S_ROW_SCAN,
      S_ROW_END,
      S_PAD,
      S_PC_SEARCH,
      S_PC_CHECK,
      S_DIV_RUN,
      S_ROT_MUL,
      S_ROT_PREP,
      S_ROT_RUN,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               endcap;
      logic [3:0]         sector;
      logic [4:0]         row;
      logic [7:0]         pad;
      logic signed [19:0] residual;
      logic signed [15:0] local_angle;
      logic signed [19:0] centre_x;
      logic signed [19:0] centre_y;
      logic signed [19:0] centre_z;
      logic [17:0]        cell_id;
   } result_type;

   function automatic logic [19:0] sat20(input logic signed [25:0] v);
      if (v > 26'sd524287) return 20'h7FFFF;
      else if (v < -26'sd524288) return 20'h80000;
      else return v[19:0];
   endfunction

   function automatic logic [17:0] pack_cell(input logic [7:0] pad, input logic [4:0] row,
                                             input logic [3:0] sec, input logic cap);
      return {cap, sec, row, pad};
   endfunction

endpackage

>>> design/hrpl_if.sv
// Request and response channel interfaces of the pad locator.
interface hrpl_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [3:0]         entry_index;
   logic signed [19:0] coord_x;
   logic signed [19:0] coord_y;
   logic signed [19:0] coord_z;
   logic [15:0]        rotation_angle;
   logic [18:0]        row_radius;
   logic [7:0]         pad_count;
   logic [18:0]        row_tolerance;
   logic [3:0]         sector_number;
   logic               endcap_in;
   logic [7:0]         pad_number;

   modport source(output valid, func, entry_index, coord_x, coord_y, coord_z, rotation_angle,
                  row_radius, pad_count, row_tolerance, sector_number, endcap_in,
                  pad_number, input ready);
   modport sink(input valid, func, entry_index, coord_x, coord_y, coord_z, rotation_angle,
                row_radius, pad_count, row_tolerance, sector_number, endcap_in,
                pad_number, output ready);
endinterface

interface hrpl_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic               endcap_out;
   logic [3:0]         sector_out;
   logic [4:0]         row_out;
   logic [7:0]         pad_out;
   logic signed [19:0] residual;
   logic signed [15:0] local_angle;
   logic signed [19:0] centre_x;
   logic signed [19:0] centre_y;
   logic signed [19:0] centre_z;
   logic [17:0]        cell_id;

   modport source(output valid, status, endcap_out, sector_out, row_out, pad_out, residual,
                  local_angle, centre_x, centre_y, centre_z, cell_id, input ready);
   modport sink(input valid, status, endcap_out, sector_out, row_out, pad_out, residual,
                local_angle, centre_x, centre_y, centre_z, cell_id, output ready);
endinterface

>>> design/hrpl_cordic.sv
// Shared iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
module hrpl_cordic #(
   parameter int STEPS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hrpl_pkg::cordic_cmd_type       cmd,
   input  logic signed [hrpl_pkg::CW_W-1:0] x_start,
   input  logic signed [hrpl_pkg::CW_W-1:0] y_start,
   input  logic signed [hrpl_pkg::CW_W-1:0] z_start,
   output logic signed [hrpl_pkg::CW_W-1:0] x_out,
   output logic signed [hrpl_pkg::CW_W-1:0] y_out,
   output logic signed [hrpl_pkg::CW_W-1:0] z_out,
   output logic                           done
);
   localparam int SCW = $clog2(STEPS);

   logic signed [hrpl_pkg::CW_W-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic signed [hrpl_pkg::CW_W-1:0] xs, ys, ang;
   logic [SCW-1:0] step_ff, step_in;
   logic mode_ff, mode_in, busy_ff, busy_in, done_ff, done_in, turn_cw;

   assign xs  = x_ff >>> step_ff;
   assign ys  = y_ff >>> step_ff;
   assign ang = {1'b0, hrpl_pkg::ATAN_TABLE[hrpl_pkg::ATAN_IW'(step_ff)]};
   // vectoring drives y to zero, rotation drives z to zero
   assign turn_cw = mode_ff ? !y_ff[hrpl_pkg::CW_W-1] : z_ff[hrpl_pkg::CW_W-1];

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      mode_in = mode_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (cmd.start) begin
         x_in    = x_start;
         y_in    = y_start;
         z_in    = z_start;
         mode_in = cmd.vectoring;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (turn_cw) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end
         if (step_ff == SCW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      mode_ff <= mode_in;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign done  = done_ff;
endmodule

>>> design/hrpl_divider.sv
// Restoring divider, one quotient bit per cycle, for the pad centre angle.
module hrpl_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hrpl_pkg::DIV_NUM_W-1:0] numer,
   input  logic [hrpl_pkg::DIV_DEN_W-1:0] denom,
   output logic [hrpl_pkg::DIV_NUM_W-1:0] quotient,
   output logic                           done
);
   localparam int NW = hrpl_pkg::DIV_NUM_W;
   localparam int DW = hrpl_pkg::DIV_DEN_W;

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DW:0]   trial;
   logic [hrpl_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in, qbit;

   assign trial = {rem_ff, num_ff[NW-1]};
   assign qbit  = (trial >= {1'b0, den_ff});

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = qbit ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
         num_in = {num_ff[NW-2:0], qbit};
         if (cnt_ff == hrpl_pkg::DIV_CNT_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = num_ff;
   assign done     = done_ff;
endmodule

>>> design/hit_to_readout_pad_locator.sv
// Top level of the hit-to-readout pad locator: sequencer, tables and result register.
// Usage: items arrive on req_ch (valid/ready). func selects load row, load sector,
// locate hit or pad centre. Each item yields exactly one result item on rsp_ch.
// Loads write the row or sector entry and mark it valid if its index is in range.
// Locate sweeps the sector slots through the single shared CORDIC unit:
// each usable sector with a nonzero offset gets a vectoring run; then the
// nearest row is found and, within the row tolerance, the pad is computed.
// Pad centre scans the sectors, runs the restoring divider for the pad
// angle and one CORDIC rotation.
// The block takes one item at a time; req_ch.ready is high only between items.
// A finished result sits in the output register; the next item is accepted
// while it waits, and the block holds its next result until rsp_ch.ready.
// Reset (synchronous) clears all row and sector valid bits and empties the
// output register.
module hit_to_readout_pad_locator #(
   parameter int ROW_COUNT    = 16,
   parameter int SECTOR_COUNT = 12,
   parameter int CORDIC_STEPS = 16
) (
   input logic        clock,
   input logic        reset,
   hrpl_req_if.sink   req_ch,
   hrpl_rsp_if.source rsp_ch
);
   localparam int RW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int SW   = $clog2(SECTOR_COUNT);
   localparam int MAXC = (ROW_COUNT > SECTOR_COUNT) ? ROW_COUNT : SECTOR_COUNT;
   localparam int CW   = $clog2(MAXC + 1);
   localparam int XW   = hrpl_pkg::CW_W;

   // tables
   logic [18:0]        radius_table_ff [ROW_COUNT];
   logic [7:0]         pads_table_ff   [ROW_COUNT];
   logic [ROW_COUNT-1:0] row_valid_ff;
   logic signed [19:0] shift_x_table_ff [SECTOR_COUNT];
   logic signed [19:0] shift_y_table_ff [SECTOR_COUNT];
   logic [15:0]        turn_table_ff    [SECTOR_COUNT];
   logic [3:0]         sector_id_table_ff [SECTOR_COUNT];
   logic [SECTOR_COUNT-1:0] sector_side_ff;
   logic [SECTOR_COUNT-1:0] sector_valid_ff;

   // latched request
   logic [3:0]         idx_ff;
   logic signed [19:0] cx_ff, cy_ff, cz_ff;
   logic [18:0]        tol_ff;
   logic [3:0]         secn_ff;
   logic               capin_ff;
   logic [7:0]         padn_ff;

   hrpl_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               found_ff, found_in, rfound_ff, rfound_in, neg_ff, neg_in;
   logic [SW-1:0]      best_ff, best_in;
   logic [RW-1:0]      brow_ff, brow_in;
   logic signed [15:0] bphi_ff, bphi_in;
   logic [21:0]        brad_ff, brad_in;
   logic signed [22:0] res_ff, res_in;
   logic [31:0]        beta_ff, beta_in;
   logic [61:0]        prod_ff, prod_in;
   hrpl_pkg::result_type result_ff, result_in, out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic accept, out_free, cap, sec_end, row_end, sec_usable, vec_zero, pc_match, pc_bad;
   logic [SW-1:0] sec_sel;
   logic [RW-1:0] row_sel, pc_row;
   logic [5:0] idx_ext, brow_p1, pc_row_p1;

   // shared units
   hrpl_pkg::cordic_cmd_type cordic_cmd;
   logic signed [XW-1:0] cx0, cy0, cz0, cx_o, cy_o, cz_o;
   logic cordic_done, div_start, div_done;
   logic [hrpl_pkg::DIV_NUM_W-1:0] div_numer, div_q;
   logic [hrpl_pkg::DIV_DEN_W-1:0] div_denom;
   logic [31:0] mul_a;
   logic [61:0] product;

   // locate datapath
   logic signed [20:0] dx, dy;
   logic signed [XW-1:0] vx0, vy0, rx0;
   logic [31:0] p32, p32r, bsum, beta2, phi32;
   logic signed [15:0] phi_now;
   logic signed [16:0] phi_ext, bphi_ext;
   logic [16:0] aphi, babs;
   logic [61:0] mag_sum, rot_sum;
   logic [21:0] mag_now;
   logic signed [22:0] rdiff;
   logic [22:0] rabs, resabs;
   logic [7:0] pn;
   logic [10:0] n6;
   logic [24:0] qprod;
   logic [7:0] q;
   logic signed [10:0] pad_s;
   logic pad_bad;

   // pad centre datapath
   logic [7:0] pc_n;
   logic signed [10:0] kval;
   logic [9:0] kabs;
   logic signed [XW-1:0] ox, oy;
   logic signed [25:0] gx, gy;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign cap      = !cz_ff[19];
   assign sec_sel  = cnt_ff[SW-1:0];
   assign row_sel  = cnt_ff[RW-1:0];
   assign idx_ext  = {2'b00, idx_ff};
   assign pc_row   = idx_ext[RW-1:0];
   assign sec_end  = (cnt_ff == CW'(SECTOR_COUNT));
   assign row_end  = (cnt_ff == CW'(ROW_COUNT));
   assign brow_p1  = 6'(brow_ff) + 6'd1;
   assign pc_row_p1 = idx_ext + 6'd1;

   // table writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff    <= '0;
         sector_valid_ff <= '0;
      end else if (accept) begin
         if (hrpl_pkg::func_type'(req_ch.func) == hrpl_pkg::FN_LOAD_ROW &&
             {2'b00, req_ch.entry_index} < 6'(ROW_COUNT)) begin
            row_valid_ff[RW'({2'b00, req_ch.entry_index})] <= 1'b1;
         end
         if (hrpl_pkg::func_type'(req_ch.func) == hrpl_pkg::FN_LOAD_SECTOR &&
             {1'b0, req_ch.entry_index} < 5'(SECTOR_COUNT)) begin
            sector_valid_ff[req_ch.entry_index[SW-1:0]] <= 1'b1;
         end
      end
      if (accept && hrpl_pkg::func_type'(req_ch.func) == hrpl_pkg::FN_LOAD_ROW &&
          {2'b00, req_ch.entry_index} < 6'(ROW_COUNT)) begin
         radius_table_ff[RW'({2'b00, req_ch.entry_index})] <= req_ch.row_radius;
         pads_table_ff[RW'({2'b00, req_ch.entry_index})]   <= req_ch.pad_count;
      end
      if (accept && hrpl_pkg::func_type'(req_ch.func) == hrpl_pkg::FN_LOAD_SECTOR &&
          {1'b0, req_ch.entry_index} < 5'(SECTOR_COUNT)) begin
         shift_x_table_ff[req_ch.entry_index[SW-1:0]]   <= req_ch.coord_x;
         shift_y_table_ff[req_ch.entry_index[SW-1:0]]   <= req_ch.coord_y;
         turn_table_ff[req_ch.entry_index[SW-1:0]]      <= req_ch.rotation_angle;
         sector_id_table_ff[req_ch.entry_index[SW-1:0]] <= req_ch.sector_number;
         sector_side_ff[req_ch.entry_index[SW-1:0]]     <= req_ch.endcap_in;
      end
      if (accept) begin
         idx_ff   <= req_ch.entry_index;
         cx_ff    <= req_ch.coord_x;
         cy_ff    <= req_ch.coord_y;
         cz_ff    <= req_ch.coord_z;
         tol_ff   <= req_ch.row_tolerance;
         secn_ff  <= req_ch.sector_number;
         capin_ff <= req_ch.endcap_in;
         padn_ff  <= req_ch.pad_number;
      end
   end

   // sector frame and vectoring start values
   assign dx  = 21'(cx_ff) - 21'(shift_x_table_ff[sec_sel]);
   assign dy  = 21'(cy_ff) - 21'(shift_y_table_ff[sec_sel]);
   assign vx0 = XW'(dx) <<< 8;
   assign vy0 = XW'(dy) <<< 8;
   assign vec_zero   = (dx == 21'sd0) && (dy == 21'sd0);
   assign sec_usable = sector_valid_ff[sec_sel] && (sector_side_ff[sec_sel] == cap);
   assign pc_match   = sector_valid_ff[sec_sel] && (sector_id_table_ff[sec_sel] == secn_ff) &&
                       (sector_side_ff[sec_sel] == capin_ff);

   // local angle and magnitude of the vectoring result
   assign p32      = 32'h4000_0000 - cz_o[31:0] + {turn_table_ff[sec_sel], 16'h0000};
   assign p32r     = p32 + 32'h0000_8000;
   assign phi_now  = p32r[31:16];
   assign phi_ext  = 17'(phi_now);
   assign aphi     = phi_ext[16] ? 17'(-phi_ext) : 17'(phi_ext);
   assign bphi_ext = 17'(bphi_ff);
   assign babs     = bphi_ext[16] ? 17'(-bphi_ext) : 17'(bphi_ext);
   assign mag_sum  = prod_ff + (62'd1 << 37);
   assign mag_now  = mag_sum[59:38];

   // nearest row
   assign rdiff  = $signed({1'b0, brad_ff}) - $signed({4'b0000, radius_table_ff[row_sel]});
   assign rabs   = rdiff[22] ? 23'(-rdiff) : 23'(rdiff);
   assign resabs = res_ff[22] ? 23'(-res_ff) : 23'(res_ff);

   // truncated pad index
   assign pn    = pads_table_ff[brow_ff];
   assign n6    = 11'({pn, 2'b00}) + 11'({pn, 1'b0});
   assign qprod = 25'(babs[12:0]) * 25'(n6);
   assign q     = qprod[23:16];
   assign pad_s = $signed({4'b0000, pn[7:1]}) +
                  (bphi_ff[15] ? -$signed({3'b000, q}) : $signed({3'b000, q})) +
                  ((!bphi_ff[15] && bphi_ff != 16'sd0) ? 11'sd1 : 11'sd0);
   assign pad_bad = (pn == 8'd0) || (pad_s < 11'sd1) || (pad_s > $signed({3'b000, pn}));

   // pad centre
   assign pc_n   = pads_table_ff[pc_row];
   assign pc_bad = (idx_ext >= 6'(ROW_COUNT)) || !row_valid_ff[pc_row] || !found_ff ||
                   (padn_ff == 8'd0) || (padn_ff > pc_n) || (cap != capin_ff);
   assign kval   = (($signed({3'b000, padn_ff}) - $signed({4'b0000, pc_n[7:1]})) <<< 1) - 11'sd1;
   assign kabs   = kval[10] ? 10'(-kval) : 10'(kval);
   assign div_numer = {kabs, 32'h0000_0000};
   assign div_denom = 12'({pc_n, 3'b000}) + 12'({pc_n, 2'b00});
   assign phi32  = neg_ff ? 32'(-div_q[31:0]) : div_q[31:0];
   assign rot_sum = prod_ff + (62'd1 << 29);
   assign rx0    = {4'b0000, rot_sum[58:30]};
   assign bsum   = beta_ff + 32'h4000_0000;
   assign beta2  = bsum[31] ? beta_ff + 32'h8000_0000 : beta_ff;
   assign ox     = (cx_o + XW'(128)) >>> 8;
   assign oy     = (cy_o + XW'(128)) >>> 8;
   assign gx     = 26'(shift_x_table_ff[best_ff]) + 26'(ox);
   assign gy     = 26'(shift_y_table_ff[best_ff]) + 26'(oy);

   // shared gain multiplier
   assign mul_a   = (state_ff == hrpl_pkg::S_ROT_MUL) ?
                    {5'b00000, radius_table_ff[pc_row], 8'h00} : cx_o[31:0];
   assign product = 62'(mul_a) * 62'(hrpl_pkg::GAIN_INV);

   always_comb begin
      if (state_ff == hrpl_pkg::S_ROT_PREP) begin
         cx0 = bsum[31] ? -rx0 : rx0;
         cy0 = '0;
         cz0 = {beta2[31], beta2};
      end else begin
         cx0 = dx[20] ? -vx0 : vx0;
         cy0 = dx[20] ? -vy0 : vy0;
         cz0 = dx[20] ? XW'(33'h0_8000_0000) : '0;
      end
   end

   hrpl_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset, .cmd(cordic_cmd), .x_start(cx0), .y_start(cy0), .z_start(cz0),
      .x_out(cx_o), .y_out(cy_o), .z_out(cz_o), .done(cordic_done)
   );

   hrpl_divider u_divider (
      .clock, .reset, .start(div_start), .numer(div_numer), .denom(div_denom),
      .quotient(div_q), .done(div_done)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hrpl_pkg::S_IDLE: begin
            if (accept) begin
               unique case (hrpl_pkg::func_type'(req_ch.func))
                  hrpl_pkg::FN_LOAD_ROW:    state_in = hrpl_pkg::S_DONE;
                  hrpl_pkg::FN_LOAD_SECTOR: state_in = hrpl_pkg::S_DONE;
                  hrpl_pkg::FN_LOCATE:      state_in = hrpl_pkg::S_SEC_CHECK;
                  hrpl_pkg::FN_PAD_CENTRE:  state_in = hrpl_pkg::S_PC_SEARCH;
                  default:                  state_in = hrpl_pkg::S_IDLE;
               endcase
            end
         end
         hrpl_pkg::S_SEC_CHECK: begin
            if (sec_end) state_in = hrpl_pkg::S_SEC_END;
            else if (sec_usable && !vec_zero) state_in = hrpl_pkg::S_VEC_RUN;
         end
         hrpl_pkg::S_VEC_RUN:  if (cordic_done) state_in = hrpl_pkg::S_MAG_MUL;
         hrpl_pkg::S_MAG_MUL:  state_in = hrpl_pkg::S_SEC_EVAL;
         hrpl_pkg::S_SEC_EVAL: state_in = hrpl_pkg::S_SEC_CHECK;
         hrpl_pkg::S_SEC_END:  state_in = found_ff ? hrpl_pkg::S_ROW_SCAN : hrpl_pkg::S_DONE;
         hrpl_pkg::S_ROW_SCAN: if (row_end) state_in = hrpl_pkg::S_ROW_END;
         hrpl_pkg::S_ROW_END: begin
            if (!rfound_ff || resabs > {4'b0000, tol_ff}) state_in = hrpl_pkg::S_DONE;
            else state_in = hrpl_pkg::S_PAD;
         end
         hrpl_pkg::S_PAD:      state_in = hrpl_pkg::S_DONE;
         hrpl_pkg::S_PC_SEARCH: if (sec_end || pc_match) state_in = hrpl_pkg::S_PC_CHECK;
         hrpl_pkg::S_PC_CHECK: state_in = pc_bad ? hrpl_pkg::S_DONE : hrpl_pkg::S_DIV_RUN;
         hrpl_pkg::S_DIV_RUN:  if (div_done) state_in = hrpl_pkg::S_ROT_MUL;
         hrpl_pkg::S_ROT_MUL:  state_in = hrpl_pkg::S_ROT_PREP;
         hrpl_pkg::S_ROT_PREP: state_in = hrpl_pkg::S_ROT_RUN;
         hrpl_pkg::S_ROT_RUN:  if (cordic_done) state_in = hrpl_pkg::S_DONE;
         hrpl_pkg::S_DONE:     if (out_free) state_in = hrpl_pkg::S_IDLE;
         default:              state_in = hrpl_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready         = (state_ff == hrpl_pkg::S_IDLE);
      cordic_cmd.start     = 1'b0;
      cordic_cmd.vectoring = 1'b1;
      div_start            = 1'b0;
      unique case (state_ff)
         hrpl_pkg::S_SEC_CHECK: cordic_cmd.start = !sec_end && sec_usable && !vec_zero;
         hrpl_pkg::S_ROT_PREP: begin
            cordic_cmd.start     = 1'b1;
            cordic_cmd.vectoring = 1'b0;
         end
         hrpl_pkg::S_PC_CHECK:  div_start = !pc_bad;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      rfound_in    = rfound_ff;
      neg_in       = neg_ff;
      best_in      = best_ff;
      brow_in      = brow_ff;
      bphi_in      = bphi_ff;
      brad_in      = brad_ff;
      res_in       = res_ff;
      beta_in      = beta_ff;
      prod_in      = prod_ff;
      result_in    = result_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      unique case (state_ff)
         hrpl_pkg::S_IDLE: begin
            if (accept) begin
               cnt_in    = '0;
               found_in  = 1'b0;
               rfound_in = 1'b0;
               result_in = '0;
            end
         end
         hrpl_pkg::S_SEC_CHECK: begin
            if (!sec_end) begin
               if (!sec_usable) begin
                  cnt_in = cnt_ff + 1'b1;
               end else if (vec_zero) begin
                  // hit on the sector origin: angle and radius zero
                  if (!found_ff || babs != 17'd0) begin
                     found_in = 1'b1;
                     best_in  = sec_sel;
                     bphi_in  = '0;
                     brad_in  = '0;
                  end
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         hrpl_pkg::S_MAG_MUL: prod_in = product;
         hrpl_pkg::S_SEC_EVAL: begin
            if (aphi <= hrpl_pkg::TWELFTH_TURN && (!found_ff || aphi < babs)) begin
               found_in = 1'b1;
               best_in  = sec_sel;
               bphi_in  = phi_now;
               brad_in  = mag_now;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         hrpl_pkg::S_SEC_END: begin
            result_in.endcap = cap;
            if (!found_ff) result_in.status = hrpl_pkg::ST_NO_SECTOR;
            cnt_in = '0;
         end
         hrpl_pkg::S_ROW_SCAN: begin
            if (!row_end) begin
               if (row_valid_ff[row_sel] && (!rfound_ff || rabs < resabs)) begin
                  rfound_in = 1'b1;
                  brow_in   = row_sel;
                  res_in    = rdiff;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         hrpl_pkg::S_ROW_END: begin
            result_in.sector      = sector_id_table_ff[best_ff];
            result_in.local_angle = bphi_ff;
            if (!rfound_ff) begin
               result_in.status = hrpl_pkg::ST_OFF_ROW;
            end else begin
               result_in.row      = brow_p1[4:0];
               result_in.residual = hrpl_pkg::sat20(26'(res_ff));
               if (resabs > {4'b0000, tol_ff}) result_in.status = hrpl_pkg::ST_OFF_ROW;
            end
         end
         hrpl_pkg::S_PAD: begin
            if (pad_bad) begin
               result_in.status = hrpl_pkg::ST_PAD_RANGE;
            end else begin
               result_in.pad     = pad_s[7:0];
               result_in.cell_id = hrpl_pkg::pack_cell(pad_s[7:0], brow_p1[4:0],
                                                       sector_id_table_ff[best_ff], cap);
            end
         end
         hrpl_pkg::S_PC_SEARCH: begin
            if (!sec_end) begin
               if (pc_match) begin
                  found_in = 1'b1;
                  best_in  = sec_sel;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         hrpl_pkg::S_PC_CHECK: begin
            if (pc_bad) result_in.status = hrpl_pkg::ST_BAD_ADDR;
            neg_in = kval[10];
         end
         hrpl_pkg::S_DIV_RUN: begin
            if (div_done) beta_in = {turn_table_ff[best_ff], 16'h0000} + 32'h4000_0000 - phi32;
         end
         hrpl_pkg::S_ROT_MUL: prod_in = product;
         hrpl_pkg::S_ROT_RUN: begin
            if (cordic_done) begin
               result_in.endcap   = capin_ff;
               result_in.sector   = secn_ff;
               result_in.row      = pc_row_p1[4:0];
               result_in.pad      = padn_ff;
               result_in.centre_x = hrpl_pkg::sat20(gx);
               result_in.centre_y = hrpl_pkg::sat20(gy);
               result_in.centre_z = cz_ff;
               result_in.cell_id  = hrpl_pkg::pack_cell(padn_ff, pc_row_p1[4:0], secn_ff,
                                                        capin_ff);
            end
         end
         default: ;
      endcase
      // output register
      if (out_valid_ff && rsp_ch.ready) out_valid_in = 1'b0;
      if (state_ff == hrpl_pkg::S_DONE && out_free) begin
         out_in       = result_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hrpl_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         rfound_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         rfound_ff    <= rfound_in;
      end
      neg_ff    <= neg_in;
      best_ff   <= best_in;
      brow_ff   <= brow_in;
      bphi_ff   <= bphi_in;
      brad_ff   <= brad_in;
      res_ff    <= res_in;
      beta_ff   <= beta_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
      out_ff    <= out_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_ff.status;
   assign rsp_ch.endcap_out  = out_ff.endcap;
   assign rsp_ch.sector_out  = out_ff.sector;
   assign rsp_ch.row_out     = out_ff.row;
   assign rsp_ch.pad_out     = out_ff.pad;
   assign rsp_ch.residual    = out_ff.residual;
   assign rsp_ch.local_angle = out_ff.local_angle;
   assign rsp_ch.centre_x    = out_ff.centre_x;
   assign rsp_ch.centre_y    = out_ff.centre_y;
   assign rsp_ch.centre_z    = out_ff.centre_z;
   assign rsp_ch.cell_id     = out_ff.cell_id;

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hrpl_pkg::S_DONE && out_free) |=> (out_valid_ff && state_ff == hrpl_pkg::S_IDLE))
      else $error("finished result not moved to the output register");

   a_cordic_start: assert property (@(posedge clock) disable iff (reset)
      cordic_cmd.start |=> (state_ff == hrpl_pkg::S_VEC_RUN || state_ff == hrpl_pkg::S_ROT_RUN))
      else $error("CORDIC started outside a run sequence");

   a_no_sector_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == 3'(hrpl_pkg::ST_NO_SECTOR)) |->
      (rsp_ch.sector_out == 4'd0 && rsp_ch.cell_id == 18'd0 && rsp_ch.row_out == 5'd0))
      else $error("no-sector result carries address fields");

endmodule
